### sv/bmo_pkg.sv
// ----------------------------------------------------------------------------
// bmo_pkg
// Shared types, widths and constants of the bicycle model odometry block.
// ----------------------------------------------------------------------------
package bmo_pkg;

	localparam int DEFAULT_POS_W = 32;

	// configuration register indexes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WHEEL_BASE  = 2'd0,
		REG_SPEED_LIMIT = 2'd1,
		REG_STEER_LIMIT = 2'd2
	} cfg_reg_t;

	localparam logic [15:0] WHEEL_BASE_RST  = 16'd10240;
	localparam logic [14:0] SPEED_LIMIT_RST = 15'd20480;
	localparam logic [13:0] STEER_LIMIT_RST = 14'd6431;

	// item kinds
	localparam logic KIND_CMD  = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// serial multiplier operand widths
	localparam int MUL_A_W = 48;
	localparam int MUL_B_W = 24;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// CORDIC
	localparam int CORDIC_W     = 34;
	localparam int CORDIC_ITERS = 16;
	localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;
	localparam logic [31:0] ATAN_TAB [CORDIC_ITERS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
	};

	// divider: 64-bit dividend, 48-bit divisor, 25 quotient bits
	localparam int DIV_N_W = 64;
	localparam int DIV_D_W = 48;
	localparam int DIV_Q_W = 25;

	// scale factors
	localparam logic signed [MUL_A_W-1:0] LAG_K      = 48'sd6554;
	localparam logic signed [MUL_A_W-1:0] STEER_K    = 48'sd83443;
	localparam logic signed [MUL_B_W-1:0] STEP_K     = 24'sd20972;
	localparam logic signed [MUL_A_W-1:0] HEADING_K  = 48'sd53404;

endpackage

### sv/bmo_if.sv
// ----------------------------------------------------------------------------
// bmo_in_if / bmo_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface bmo_in_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic signed [15:0] cmd_speed;
	logic signed [15:0] cmd_steer;

	modport source (output valid, kind, cmd_speed, cmd_steer, input ready);
	modport sink   (input valid, kind, cmd_speed, cmd_steer, output ready);
endinterface

interface bmo_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [15:0] heading;
	logic signed [15:0] quat_w;
	logic signed [15:0] quat_z;
	logic signed [15:0] speed_out;
	logic signed [23:0] yaw_rate;

	modport source (output valid, pos_x, pos_y, heading, quat_w, quat_z, speed_out,
		yaw_rate, input ready);
	modport sink   (input valid, pos_x, pos_y, heading, quat_w, quat_z, speed_out,
		yaw_rate, output ready);
endinterface

### sv/bmo_mul.sv
// ----------------------------------------------------------------------------
// bmo_mul
// Signed shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module bmo_mul (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [bmo_pkg::MUL_A_W-1:0]   a,
	input  logic signed [bmo_pkg::MUL_B_W-1:0]   b,
	output logic signed [bmo_pkg::MUL_P_W-1:0]   p,
	output logic                                 done
);
	import bmo_pkg::*;

	localparam int CNT_W = $clog2(MUL_B_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(MUL_B_W - 1);

	logic signed [MUL_P_W-1:0] a_q;
	logic signed [MUL_B_W-1:0] b_q;
	logic signed [MUL_P_W-1:0] p_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic signed [MUL_P_W-1:0] term;

	assign term = b_q[0] ? a_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= MUL_P_W'(a);
			b_q <= b;
			p_q <= '0;
		end else if (busy_q) begin
			// top bit of b carries negative weight
			p_q <= (cnt_q == LAST) ? p_q - term : p_q + term;
			a_q <= a_q <<< 1;
			b_q <= b_q >>> 1;
		end
	end

	assign p    = p_q;
	assign done = done_q;
endmodule

### sv/bmo_cordic.sv
// ----------------------------------------------------------------------------
// bmo_cordic
// Rotation-mode CORDIC, one iteration per cycle, cos/sin of a binary angle.
// ----------------------------------------------------------------------------
module bmo_cordic (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [31:0]                           angle,
	output logic signed [bmo_pkg::CORDIC_W-1:0]   cos_o,
	output logic signed [bmo_pkg::CORDIC_W-1:0]   sin_o,
	output logic                                  done
);
	import bmo_pkg::*;

	localparam int IT_W = $clog2(CORDIC_ITERS);
	localparam logic [IT_W-1:0] LAST = IT_W'(CORDIC_ITERS - 1);

	logic signed [CORDIC_W-1:0] x_q, y_q, z_q;
	logic [IT_W-1:0]            it_q;
	logic                       neg_q;
	logic                       busy_q;
	logic                       done_q;
	logic [31:0]                fold;
	logic signed [CORDIC_W-1:0] ys, xs, at;

	// second and third quadrants fold over by pi, negate at the end
	assign fold = (angle[31] ^ angle[30]) ? {~angle[31], angle[30:0]} : angle;
	assign ys   = y_q >>> it_q;
	assign xs   = x_q >>> it_q;
	assign at   = CORDIC_W'(ATAN_TAB[it_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			it_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				it_q   <= '0;
			end else if (busy_q) begin
				it_q <= it_q + 1'b1;
				if (it_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= angle[31] ^ angle[30];
			x_q   <= CORDIC_X0;
			y_q   <= '0;
			z_q   <= CORDIC_W'($signed(fold));
		end else if (busy_q) begin
			if (!z_q[CORDIC_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign cos_o = neg_q ? -x_q : x_q;
	assign sin_o = neg_q ? -y_q : y_q;
	assign done  = done_q;
endmodule

### sv/bmo_div.sv
// ----------------------------------------------------------------------------
// bmo_div
// Restoring unsigned divider, one quotient bit per cycle, with overflow flag.
// ----------------------------------------------------------------------------
module bmo_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [bmo_pkg::DIV_N_W-1:0]   num,
	input  logic [bmo_pkg::DIV_D_W-1:0]   den,
	output logic [bmo_pkg::DIV_Q_W-1:0]   quo,
	output logic                          ovf,
	output logic                          done
);
	import bmo_pkg::*;

	localparam int SH_W  = DIV_D_W + DIV_Q_W;
	localparam int CNT_W = $clog2(DIV_Q_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_Q_W - 1);

	logic [DIV_N_W-1:0] r_q;
	logic [SH_W-1:0]    d_q;
	logic [DIV_Q_W-1:0] q_q;
	logic               ovf_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic               ge;

	assign ge = SH_W'(r_q) >= d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// quotient would not fit in DIV_Q_W bits (also covers a zero divisor)
			ovf_q <= SH_W'(num) >= {den, {DIV_Q_W{1'b0}}};
			r_q   <= num;
			d_q   <= {1'b0, den, {(DIV_Q_W-1){1'b0}}};
			q_q   <= '0;
		end else if (busy_q) begin
			if (ge)
				r_q <= r_q - d_q[DIV_N_W-1:0];
			q_q <= {q_q[DIV_Q_W-2:0], ge};
			d_q <= d_q >> 1;
		end
	end

	assign quo  = q_q;
	assign ovf  = ovf_q;
	assign done = done_q;
endmodule

### sv/bicycle_model_odometry.sv
// ----------------------------------------------------------------------------
// bicycle_model_odometry
// Fixed-point kinematic bicycle odometry with first-order lag on commands.
// ----------------------------------------------------------------------------
// One item at a time. A command runs two products on the serial multiplier; a
// tick runs eight products (each of 24 shift steps plus start and finish) on
// the one shared bit-serial multiplier, three CORDIC runs and a divide for
// 25 quotient bits, all in sequence. The input is ready only while the
// sequencer is idle; a finished result sits in the output register, and a
// next item is taken while it waits. Configuration writes are taken at any
// time and should come only while the block is idle.
module bicycle_model_odometry #(
	parameter int POSITION_WIDTH = bmo_pkg::DEFAULT_POS_W
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bmo_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [bmo_pkg::CFG_DATA_W-1:0]    cfg_data,
	bmo_in_if.sink                            in_ch,
	bmo_out_if.source                         out_ch
);
	import bmo_pkg::*;

	localparam int PW = POSITION_WIDTH;
	localparam int XW = 49;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CMD_V, ST_CMD_S, ST_SA, ST_CS1, ST_NUM, ST_DEN, ST_DIV,
		ST_CS2, ST_PX1, ST_PX2, ST_PY1, ST_PY2, ST_HD, ST_CS3, ST_OUT
	} state_t;

	state_t state_q;

	logic [15:0] wb_q;
	logic [14:0] vlim_q;
	logic [13:0] slim_q;

	logic signed [PW-1:0] x_q, y_q;
	logic [15:0]          hd_q;
	logic signed [15:0]   fv_q, fs_q;
	logic signed [15:0]   cs_q;
	logic signed [47:0]   num_q, den_q;
	logic signed [23:0]   yaw_q;

	logic                       mul_go_q, cor_go_q, div_go_q;
	logic signed [MUL_A_W-1:0]  mul_a_q;
	logic signed [MUL_B_W-1:0]  mul_b_q;
	logic [31:0]                cor_ang_q;

	logic                        out_valid_q;
	logic signed [31:0]          o_x_q, o_y_q;
	logic [15:0]                 o_hd_q;
	logic signed [15:0]          o_qw_q, o_qz_q, o_v_q;
	logic signed [23:0]          o_yaw_q;

	logic signed [MUL_P_W-1:0]   mul_p;
	logic                        mul_done;
	logic signed [CORDIC_W-1:0]  cor_c, cor_s;
	logic                        cor_done;
	logic [DIV_Q_W-1:0]          div_q;
	logic                        div_ovf, div_done;

	bmo_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_go_q), .a(mul_a_q), .b(mul_b_q),
		.p(mul_p), .done(mul_done)
	);

	bmo_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cor_go_q), .angle(cor_ang_q),
		.cos_o(cor_c), .sin_o(cor_s), .done(cor_done)
	);

	logic [47:0] num_abs, den_abs;
	assign num_abs = num_q[47] ? 48'(-num_q) : 48'(num_q);
	assign den_abs = den_q[47] ? 48'(-den_q) : 48'(den_q);

	bmo_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go_q),
		.num({num_abs, 16'b0}), .den(den_abs),
		.quo(div_q), .ovf(div_ovf), .done(div_done)
	);

	// ---------------- datapath helpers ----------------
	logic signed [16:0] vlim_s, slim_s, cmd_v, cmd_s;
	logic signed [15:0] cv_c, cs_c;
	logic signed [16:0] dv_c, ds_c;
	logic signed [MUL_P_W-1:0] lag_sum, stp_sum, hst_sum;
	logic signed [15:0] delta_c;
	logic signed [17:0] step_c;
	logic [15:0]        hstep_c, hd_new_c;
	logic signed [PW:0] x_sum, y_sum;
	logic signed [PW-1:0] x_next, y_next;
	logic signed [23:0] yaw_c;
	logic               yneg;
	logic signed [XW-1:0] xe, ye;
	logic signed [31:0] x32, y32;
	logic signed [CORDIC_W-1:0] qw_sum, qz_sum;
	logic signed [17:0] qw_r, qz_r;
	logic signed [15:0] qw_c, qz_c;
	logic               out_free;

	always_comb begin
		vlim_s = 17'($signed({1'b0, vlim_q}));
		slim_s = 17'($signed({1'b0, slim_q}));
		cmd_v  = 17'(in_ch.cmd_speed);
		cmd_s  = 17'(in_ch.cmd_steer);
		if (cmd_v > vlim_s)
			cv_c = 16'(vlim_s);
		else if (cmd_v < -vlim_s)
			cv_c = 16'(-vlim_s);
		else
			cv_c = in_ch.cmd_speed;
		if (cmd_s > slim_s)
			cs_c = 16'(slim_s);
		else if (cmd_s < -slim_s)
			cs_c = 16'(-slim_s);
		else
			cs_c = in_ch.cmd_steer;
		dv_c = 17'(cv_c) - 17'(fv_q);
		ds_c = 17'(cs_q) - 17'(fs_q);

		lag_sum = mul_p + MUL_P_W'(32768);
		delta_c = lag_sum[31:16];

		stp_sum = mul_p + (MUL_P_W'(1) <<< 45);
		step_c  = stp_sum[63:46];
		x_sum   = (PW+1)'(x_q) + (PW+1)'(step_c);
		y_sum   = (PW+1)'(y_q) + (PW+1)'(step_c);
		if (x_sum[PW] != x_sum[PW-1])
			x_next = x_sum[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
		else
			x_next = x_sum[PW-1:0];
		if (y_sum[PW] != y_sum[PW-1])
			y_next = y_sum[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
		else
			y_next = y_sum[PW-1:0];

		hst_sum  = mul_p + (MUL_P_W'(1) <<< 23);
		hstep_c  = hst_sum[39:24];
		hd_new_c = hd_q + hstep_c;

		// zero counts as positive for the sign of the quotient
		yneg = num_q[47] != den_q[47];
		if (num_q == '0)
			yaw_c = '0;
		else if (div_ovf)
			yaw_c = yneg ? -24'sd8388608 : 24'sd8388607;
		else if (yneg)
			yaw_c = (div_q > 25'd8388608) ? -24'sd8388608 : 24'(-div_q);
		else
			yaw_c = (div_q > 25'd8388607) ? 24'sd8388607 : 24'(div_q);

		xe = XW'(x_q);
		ye = XW'(y_q);
		if (xe > 49'sd2147483647)
			x32 = 32'sh7FFFFFFF;
		else if (xe < -49'sd2147483648)
			x32 = 32'sh80000000;
		else
			x32 = xe[31:0];
		if (ye > 49'sd2147483647)
			y32 = 32'sh7FFFFFFF;
		else if (ye < -49'sd2147483648)
			y32 = 32'sh80000000;
		else
			y32 = ye[31:0];

		qw_sum = cor_c + CORDIC_W'(32768);
		qz_sum = cor_s + CORDIC_W'(32768);
		qw_r   = qw_sum[33:16];
		qz_r   = qz_sum[33:16];
		if (qw_r > 18'sd16384)
			qw_c = 16'sd16384;
		else if (qw_r < -18'sd16384)
			qw_c = -16'sd16384;
		else
			qw_c = qw_r[15:0];
		if (qz_r > 18'sd16384)
			qz_c = 16'sd16384;
		else if (qz_r < -18'sd16384)
			qz_c = -16'sd16384;
		else
			qz_c = qz_r[15:0];

		out_free = !out_valid_q || out_ch.ready;
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wb_q        <= WHEEL_BASE_RST;
			vlim_q      <= SPEED_LIMIT_RST;
			slim_q      <= STEER_LIMIT_RST;
			x_q         <= '0;
			y_q         <= '0;
			hd_q        <= '0;
			fv_q        <= '0;
			fs_q        <= '0;
			cs_q        <= '0;
			num_q       <= '0;
			den_q       <= '0;
			yaw_q       <= '0;
			mul_go_q    <= 1'b0;
			cor_go_q    <= 1'b0;
			div_go_q    <= 1'b0;
			mul_a_q     <= '0;
			mul_b_q     <= '0;
			cor_ang_q   <= '0;
			out_valid_q <= 1'b0;
			o_x_q       <= '0;
			o_y_q       <= '0;
			o_hd_q      <= '0;
			o_qw_q      <= '0;
			o_qz_q      <= '0;
			o_v_q       <= '0;
			o_yaw_q     <= '0;
		end else begin
			mul_go_q <= 1'b0;
			cor_go_q <= 1'b0;
			div_go_q <= 1'b0;

			if (cfg_we) begin
				unique case (cfg_idx)
					REG_WHEEL_BASE:  wb_q   <= cfg_data;
					REG_SPEED_LIMIT: vlim_q <= cfg_data[14:0];
					REG_STEER_LIMIT: slim_q <= cfg_data[13:0];
					default: ;
				endcase
			end

			if (out_valid_q && out_ch.ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						mul_go_q <= 1'b1;
						if (in_ch.kind == KIND_CMD) begin
							cs_q    <= cs_c;
							mul_a_q <= LAG_K;
							mul_b_q <= MUL_B_W'(dv_c);
							state_q <= ST_CMD_V;
						end else begin
							mul_a_q <= STEER_K;
							mul_b_q <= MUL_B_W'(fs_q);
							state_q <= ST_SA;
						end
					end
				end
				ST_CMD_V: begin
					if (mul_done) begin
						fv_q     <= fv_q + delta_c;
						mul_b_q  <= MUL_B_W'(ds_c);
						mul_go_q <= 1'b1;
						state_q  <= ST_CMD_S;
					end
				end
				ST_CMD_S: begin
					if (mul_done) begin
						fs_q    <= fs_q + delta_c;
						state_q <= ST_IDLE;
					end
				end
				ST_SA: begin
					if (mul_done) begin
						cor_ang_q <= mul_p[31:0];
						cor_go_q  <= 1'b1;
						state_q   <= ST_CS1;
					end
				end
				ST_CS1: begin
					if (cor_done) begin
						mul_a_q  <= MUL_A_W'(cor_s);
						mul_b_q  <= MUL_B_W'(fv_q);
						mul_go_q <= 1'b1;
						state_q  <= ST_NUM;
					end
				end
				ST_NUM: begin
					if (mul_done) begin
						num_q    <= mul_p[47:0];
						mul_a_q  <= MUL_A_W'(cor_c);
						mul_b_q  <= MUL_B_W'($signed({1'b0, wb_q}));
						mul_go_q <= 1'b1;
						state_q  <= ST_DEN;
					end
				end
				ST_DEN: begin
					if (mul_done) begin
						den_q    <= mul_p[47:0];
						div_go_q <= 1'b1;
						state_q  <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						yaw_q     <= yaw_c;
						cor_ang_q <= {hd_q, 16'b0};
						cor_go_q  <= 1'b1;
						state_q   <= ST_CS2;
					end
				end
				ST_CS2: begin
					if (cor_done) begin
						mul_a_q  <= MUL_A_W'(cor_c);
						mul_b_q  <= MUL_B_W'(fv_q);
						mul_go_q <= 1'b1;
						state_q  <= ST_PX1;
					end
				end
				ST_PX1: begin
					if (mul_done) begin
						mul_a_q  <= mul_p[MUL_A_W-1:0];
						mul_b_q  <= STEP_K;
						mul_go_q <= 1'b1;
						state_q  <= ST_PX2;
					end
				end
				ST_PX2: begin
					if (mul_done) begin
						x_q      <= x_next;
						mul_a_q  <= MUL_A_W'(cor_s);
						mul_b_q  <= MUL_B_W'(fv_q);
						mul_go_q <= 1'b1;
						state_q  <= ST_PY1;
					end
				end
				ST_PY1: begin
					if (mul_done) begin
						mul_a_q  <= mul_p[MUL_A_W-1:0];
						mul_b_q  <= STEP_K;
						mul_go_q <= 1'b1;
						state_q  <= ST_PY2;
					end
				end
				ST_PY2: begin
					if (mul_done) begin
						y_q      <= y_next;
						mul_a_q  <= HEADING_K;
						mul_b_q  <= yaw_q;
						mul_go_q <= 1'b1;
						state_q  <= ST_HD;
					end
				end
				ST_HD: begin
					if (mul_done) begin
						hd_q      <= hd_new_c;
						// half heading as a 32-bit binary angle
						cor_ang_q <= {hd_new_c[15], hd_new_c, 15'b0};
						cor_go_q  <= 1'b1;
						state_q   <= ST_CS3;
					end
				end
				ST_CS3, ST_OUT: begin
					if (state_q == ST_OUT || cor_done) begin
						if (out_free) begin
							out_valid_q <= 1'b1;
							o_x_q       <= x32;
							o_y_q       <= y32;
							o_hd_q      <= hd_q;
							o_qw_q      <= qw_c;
							o_qz_q      <= qz_c;
							o_v_q       <= fv_q;
							o_yaw_q     <= yaw_q;
							state_q     <= ST_IDLE;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ch.ready      = (state_q == ST_IDLE);
	assign out_ch.valid     = out_valid_q;
	assign out_ch.pos_x     = o_x_q;
	assign out_ch.pos_y     = o_y_q;
	assign out_ch.heading   = o_hd_q;
	assign out_ch.quat_w    = o_qw_q;
	assign out_ch.quat_z    = o_qz_q;
	assign out_ch.speed_out = o_v_q;
	assign out_ch.yaw_rate  = o_yaw_q;
endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bicycle_model_odometry. A queue-fed driver sends
// command and tick items. Each accepted item goes through a bit-accurate pose
// predictor. A monitor compares every pose result with the oldest prediction.
// The run covers several limit settings and random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
	import bmo_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 400;
	localparam longint POS32_MIN  = -64'sd2147483648;
	localparam longint POS32_MAX  = 64'sd2147483647;

	typedef struct packed {
		logic               kind;
		logic signed [15:0] speed;
		logic signed [15:0] steer;
	} odo_item_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [15:0] heading;
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_z;
		logic signed [15:0] speed_out;
		logic signed [23:0] yaw_rate;
	} pose_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	bmo_in_if  in_ch();
	bmo_out_if out_ch();

	bicycle_model_odometry dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	always #1 clk = ~clk;

	odo_item_t feed_q[$];
	pose_t     pose_q[$];
	int        mismatches = 0;
	bit        calm = 1'b0;
	bit        hold = 1'b0;

	// predictor state
	logic [15:0]        wb_sh    = WHEEL_BASE_RST;
	logic [14:0]        vlim_sh  = SPEED_LIMIT_RST;
	logic [13:0]        slim_sh  = STEER_LIMIT_RST;
	longint             x_st = 0, y_st = 0;
	logic [15:0]        hdg_st = '0;
	logic signed [15:0] spd_st = '0, str_st = '0;

	function automatic longint clamp64(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// cos/sin of a 32-bit binary angle, Q2.30
	task automatic cordic_rot(input logic [31:0] ang, output longint c, output longint s);
		longint x, y, z, t;
		bit     neg;
		neg = (ang[31:30] == 2'd1 || ang[31:30] == 2'd2);
		if (neg)
			ang[31] = ~ang[31];
		x = 652032874;
		y = 0;
		z = longint'($signed(ang));
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			t = x;
			if (z >= 0) begin
				x = x - (y >>> i); y = y + (t >>> i); z = z - longint'(ATAN_TAB[i]);
			end else begin
				x = x + (y >>> i); y = y - (t >>> i); z = z + longint'(ATAN_TAB[i]);
			end
		end
		c = neg ? -x : x;
		s = neg ? -y : y;
	endtask

	function automatic logic signed [15:0] lag_step(logic signed [15:0] old, longint cmd);
		longint d;
		d = cmd - longint'(old);
		return 16'(longint'(old) + ((d * 6554 + 32768) >>> 16));
	endfunction

	task automatic advance_odometry(input odo_item_t it);
		longint v, sc, ss, hc, hs, num, den, yaw, prod, hstep;
		logic [63:0] unum, uden, q;
		bit yneg;
		pose_t p;
		if (it.kind == KIND_CMD) begin
			spd_st = lag_step(spd_st, clamp64(longint'(it.speed), -longint'(vlim_sh),
				longint'(vlim_sh)));
			str_st = lag_step(str_st, clamp64(longint'(it.steer), -longint'(slim_sh),
				longint'(slim_sh)));
			return;
		end
		v = spd_st;
		prod = longint'(str_st) * 83443;
		cordic_rot(prod[31:0], sc, ss);
		num = v * ss;
		den = longint'(wb_sh) * sc;
		yneg = (num < 0) != (den < 0);
		unum = 64'(num < 0 ? -num : num) << 16;
		uden = 64'(den < 0 ? -den : den);
		if (unum == 0)
			yaw = 0;
		else begin
			q = (uden == 0) ? 64'hFFFF_FFFF : unum / uden;
			if (yneg)
				yaw = (q > 64'd8388608) ? -8388608 : -longint'(q);
			else
				yaw = (q > 64'd8388607) ? 8388607 : longint'(q);
		end
		cordic_rot({hdg_st, 16'h0}, hc, hs);
		x_st = clamp64(x_st + ((v * hc * 20972 + (64'sd1 <<< 45)) >>> 46),
			POS32_MIN, POS32_MAX);
		y_st = clamp64(y_st + ((v * hs * 20972 + (64'sd1 <<< 45)) >>> 46),
			POS32_MIN, POS32_MAX);
		hstep = (yaw * 53404 + (64'sd1 <<< 23)) >>> 24;
		hdg_st = hdg_st + hstep[15:0];
		prod = longint'($signed(hdg_st)) * 32768;
		cordic_rot(prod[31:0], hc, hs);
		p.pos_x     = 32'(x_st);
		p.pos_y     = 32'(y_st);
		p.heading   = hdg_st;
		p.quat_w    = 16'(clamp64((hc + 32768) >>> 16, -16384, 16384));
		p.quat_z    = 16'(clamp64((hs + 32768) >>> 16, -16384, 16384));
		p.speed_out = spd_st;
		p.yaw_rate  = 24'(yaw);
		pose_q.push_back(p);
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_ch.valid     <= 1'b0;
			in_ch.kind      <= KIND_CMD;
			in_ch.cmd_speed <= '0;
			in_ch.cmd_steer <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				advance_odometry({in_ch.kind, in_ch.cmd_speed, in_ch.cmd_steer});
			if (!in_ch.valid || in_ch.ready) begin
				if (feed_q.size() != 0 && !hold && (calm || $urandom_range(99) >= 25)) begin
					odo_item_t it;
					it = feed_q.pop_front();
					in_ch.valid     <= 1'b1;
					in_ch.kind      <= it.kind;
					in_ch.cmd_speed <= it.speed;
					in_ch.cmd_steer <= it.steer;
				end else
					in_ch.valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (!arst_n)
			out_ch.ready <= 1'b0;
		else begin
			if (out_ch.valid && out_ch.ready) begin
				pose_t got, want;
				got = {out_ch.pos_x, out_ch.pos_y, out_ch.heading, out_ch.quat_w,
					out_ch.quat_z, out_ch.speed_out, out_ch.yaw_rate};
				if (pose_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected pose result %p", got);
				end else begin
					want = pose_q.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("pose mismatch: expected %p got %p", want, got);
					end
				end
			end
			out_ch.ready <= calm || $urandom_range(99) >= 25;
		end
	end

	// watchdog on cycles without any transfer
	int quiet = 0;
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet <= 0;
		else if (quiet >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else
			quiet <= quiet + 1;
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_WHEEL_BASE:  wb_sh   = val;
			REG_SPEED_LIMIT: vlim_sh = val[14:0];
			REG_STEER_LIMIT: slim_sh = val[13:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		wait (feed_q.size() == 0 && !in_ch.valid && pose_q.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push(input logic k, input logic [15:0] s, input logic [15:0] a);
		feed_q.push_back({k, s, a});
	endtask

	// runs of a repeated command, so the lag settles, then a few ticks and now and then one random item
	task automatic random_drive(input int n);
		int left;
		logic [15:0] s, a;
		left = n;
		while (left > 0) begin
			s = 16'($urandom);
			a = 16'($urandom);
			if ($urandom_range(3) == 0)
				s = $urandom_range(1) ? 16'h7FFF : 16'h8000;
			for (int i = $urandom_range(30, 1); i > 0 && left > 0; i--, left--)
				push(KIND_CMD, s, a);
			for (int i = $urandom_range(10, 1); i > 0 && left > 0; i--, left--)
				push(KIND_TICK, 16'($urandom), 16'($urandom));
			if ($urandom_range(9) == 0 && left > 0) begin
				push(1'($urandom_range(1)), 16'($urandom), 16'($urandom));
				left--;
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: tick from rest, field extremes, out-of-range register index
		push(KIND_TICK, 16'h0, 16'h0);
		push(KIND_CMD, 16'h7FFF, 16'h7FFF);
		push(KIND_TICK, 16'h0, 16'h0);
		push(KIND_CMD, 16'h8000, 16'h8000);
		push(KIND_TICK, 16'hFFFF, 16'hFFFF);
		push(KIND_CMD, 16'h0, 16'h0);
		push(KIND_TICK, 16'h0, 16'h0);
		drain();
		write_reg(REG_UNUSED, 16'h0001);
		for (int i = 0; i < 12; i++)
			push(KIND_CMD, 16'h7FFF, 16'h8000);
		for (int i = 0; i < 6; i++)
			push(KIND_TICK, 16'h0, 16'h0);
		random_drive(400);
		drain();

		// extreme limits, tiny wheelbase: yaw saturates, heading wraps fast
		calm = 1'b1;
		write_reg(REG_WHEEL_BASE, 16'd1024);
		write_reg(REG_SPEED_LIMIT, 16'hFFFF);
		write_reg(REG_STEER_LIMIT, 16'hFFFF);
		random_drive(450);
		drain();
		calm = 1'b0;

		// opposite extremes
		write_reg(REG_WHEEL_BASE, 16'd65535);
		write_reg(REG_SPEED_LIMIT, 16'd0);
		write_reg(REG_STEER_LIMIT, 16'd0);
		random_drive(100);
		drain();

		// random in-range settings
		for (int ph = 0; ph < 2; ph++) begin
			write_reg(REG_WHEEL_BASE, 16'($urandom_range(65535, 1024)));
			write_reg(REG_SPEED_LIMIT, 16'($urandom_range(32767)));
			write_reg(REG_STEER_LIMIT, 16'($urandom_range(12288)));
			random_drive(200);
			if (ph == 0) begin
				wait (feed_q.size() < 100);
				hold = 1'b1;
				wait (pose_q.size() == 0);
				hold = 1'b0;
			end
			random_drive(200);
			drain();
		end

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

### filelist.f
sv/bmo_pkg.sv
sv/bmo_if.sv
sv/bmo_mul.sv
sv/bmo_cordic.sv
sv/bmo_div.sv
sv/bicycle_model_odometry.sv
verif/tb.sv
